[design/sha256_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and bit functions of the SHA-256 digest engine.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_HADD,
    ST_PAD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_val;
    logic       step;
  } sched_ctl_t;

  typedef struct packed {
    logic load;
    logic step;
    logic hadd;
    logic init;
  } core_ctl_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

[design/sha256_sched.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_sched
// 16-word message schedule window: byte-wise fill, one word per round out.
// ----------------------------------------------------------------------------
module sha256_sched (
  input  logic                   clk,
  input  sha256_pkg::sched_ctl_t ctl,
  output logic [31:0]            w_cur
);

  logic [31:0] win_r   [16];
  logic [31:0] win_nxt [16];
  logic [31:0] w_new;

  // Window holds W[t]..W[t+15] at round t; W[t+16] is formed alongside.
  assign w_new = sha256_pkg::small_sigma1(win_r[14]) + win_r[9]
               + sha256_pkg::small_sigma0(win_r[1]) + win_r[0];
  assign w_cur = win_r[0];

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      win_nxt[k] = win_r[k];
    end
    if (ctl.shift_byte) begin
      // whole window acts as one big-endian byte shift line
      for (int k = 0; k < 15; k++) begin
        win_nxt[k] = {win_r[k][23:0], win_r[k+1][31:24]};
      end
      win_nxt[15] = {win_r[15][23:0], ctl.byte_val};
    end else if (ctl.step) begin
      for (int k = 0; k < 15; k++) begin
        win_nxt[k] = win_r[k+1];
      end
      win_nxt[15] = w_new;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 16; k++) begin
      win_r[k] <= win_nxt[k];
    end
  end

endmodule

[design/sha256_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_core
// Round unit with working variables a..h and the running hash value.
// ----------------------------------------------------------------------------
module sha256_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha256_pkg::core_ctl_t ctl,
  input  logic [31:0]           k_cur,
  input  logic [31:0]           w_cur,
  input  logic [2:0]            rd_idx,
  output logic [31:0]           rd_word
);

  logic [31:0] hash_r [8];
  logic [31:0] v_r    [8];
  logic [31:0] ch, maj, t1, t2;

  assign ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1  = v_r[7] + sha256_pkg::big_sigma1(v_r[4]) + ch + k_cur + w_cur;
  assign t2  = sha256_pkg::big_sigma0(v_r[0]) + maj;

  assign rd_word = hash_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 8; k++) begin
        hash_r[k] <= sha256_pkg::HASH_INIT[k];
      end
    end else if (ctl.init) begin
      for (int k = 0; k < 8; k++) begin
        hash_r[k] <= sha256_pkg::HASH_INIT[k];
      end
    end else if (ctl.hadd) begin
      for (int k = 0; k < 8; k++) begin
        hash_r[k] <= hash_r[k] + v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int k = 0; k < 8; k++) begin
        v_r[k] <= hash_r[k];
      end
    end else if (ctl.step) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

endmodule

[design/sha256_message_digest.sv]
`timescale 1ns / 1ps
// Input: a message byte is taken only in idle; the byte that fills a 64-byte block
//   keeps the input stalled for the 64 rounds on one round unit plus the hash add.
// Finish: padding bytes go through the byte path one per cycle (64 - pos, plus
//   64 when the marker spills), then each block is compressed, then 8 digest transactions.
// Input stalls while the single round unit compresses a block and while padding or output runs.
// Reset: synchronous active-low rst_n loads the initial hash and clears counters.
// ----------------------------------------------------------------------------
// sha256_message_digest
// SHA-256 digest of a byte stream with padding and word-wise digest output.
// ----------------------------------------------------------------------------
module sha256_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_msg_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha256_pkg::state_t     state_r, state_nxt;
  sha256_pkg::sched_ctl_t sched_ctl;
  sha256_pkg::core_ctl_t  core_ctl;

  logic [5:0]  byte_cnt_r;
  logic [60:0] msg_len_r;
  logic [5:0]  round_r;
  logic [2:0]  idx_r;
  logic        pad_act_r, pad_first_r, final_blk_r;

  logic        in_acc, out_acc, out_done, blk_full;
  logic [63:0] bit_len;
  logic [2:0]  len_sel;
  logic [7:0]  pad_byte;
  logic [31:0] w_cur;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign out_done = out_acc && (idx_r == 3'd7);
  assign blk_full = sched_ctl.shift_byte && (byte_cnt_r == 6'd63);

  assign bit_len = {msg_len_r, 3'b000};
  assign len_sel = 3'd7 - byte_cnt_r[2:0];

  always_comb begin
    if (pad_first_r) begin
      pad_byte = sha256_pkg::PAD_MARK;
    end else if (final_blk_r && (byte_cnt_r >= sha256_pkg::LEN_START)) begin
      pad_byte = bit_len[{len_sel, 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha256_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_req_type) begin
            state_nxt = sha256_pkg::ST_PAD;
          end else if (blk_full) begin
            state_nxt = sha256_pkg::ST_ROUND;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        if (blk_full) begin
          state_nxt = sha256_pkg::ST_ROUND;
        end
      end
      sha256_pkg::ST_ROUND: begin
        if (round_r == 6'd63) begin
          state_nxt = sha256_pkg::ST_HADD;
        end
      end
      sha256_pkg::ST_HADD: begin
        if (!pad_act_r) begin
          state_nxt = sha256_pkg::ST_IDLE;
        end else if (final_blk_r) begin
          state_nxt = sha256_pkg::ST_OUT;
        end else begin
          state_nxt = sha256_pkg::ST_PAD;
        end
      end
      sha256_pkg::ST_OUT: begin
        if (out_done) begin
          state_nxt = sha256_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha256_pkg::ST_IDLE;
    endcase
  end

  // outputs and unit controls
  always_comb begin
    in_stall             = (state_r != sha256_pkg::ST_IDLE);
    out_valid            = (state_r == sha256_pkg::ST_OUT);
    sched_ctl.shift_byte = (in_valid && !in_stall && !in_req_type)
                         || (state_r == sha256_pkg::ST_PAD);
    sched_ctl.byte_val   = (state_r == sha256_pkg::ST_PAD) ? pad_byte : in_msg_byte;
    sched_ctl.step       = (state_r == sha256_pkg::ST_ROUND);
    core_ctl.load        = sched_ctl.shift_byte && (byte_cnt_r == 6'd63);
    core_ctl.step        = (state_r == sha256_pkg::ST_ROUND);
    core_ctl.hadd        = (state_r == sha256_pkg::ST_HADD);
    core_ctl.init        = out_valid && !out_stall && (idx_r == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha256_pkg::ST_IDLE;
      byte_cnt_r  <= '0;
      msg_len_r   <= '0;
      round_r     <= '0;
      idx_r       <= '0;
      pad_act_r   <= 1'b0;
      pad_first_r <= 1'b0;
      final_blk_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (sched_ctl.shift_byte) begin
        byte_cnt_r <= byte_cnt_r + 6'd1;
      end
      if (in_acc && !in_req_type) begin
        msg_len_r <= msg_len_r + 61'd1;
      end
      if (blk_full) begin
        round_r <= '0;
      end else if (state_r == sha256_pkg::ST_ROUND) begin
        round_r <= round_r + 6'd1;
      end
      if (in_acc && in_req_type) begin
        pad_act_r   <= 1'b1;
        pad_first_r <= 1'b1;
        final_blk_r <= (byte_cnt_r < sha256_pkg::LEN_START);
      end
      if (state_r == sha256_pkg::ST_PAD) begin
        pad_first_r <= 1'b0;
      end
      if ((state_r == sha256_pkg::ST_HADD) && pad_act_r) begin
        final_blk_r <= 1'b1;
      end
      if (out_acc) begin
        idx_r <= idx_r + 3'd1;
      end
      if (out_done) begin
        msg_len_r   <= '0;
        byte_cnt_r  <= '0;
        pad_act_r   <= 1'b0;
        final_blk_r <= 1'b0;
      end
    end
  end

  sha256_sched u_sched (
    .clk   (clk),
    .ctl   (sched_ctl),
    .w_cur (w_cur)
  );

  sha256_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (core_ctl),
    .k_cur   (sha256_pkg::ROUND_K[round_r]),
    .w_cur   (w_cur),
    .rd_idx  (idx_r),
    .rd_word (out_digest_word)
  );

  assign out_word_index = idx_r;
  assign out_last_word  = (idx_r == 3'd7);

`ifndef SYNTH
  // a block-filling byte starts the compression at round zero
  a_blk_start: assert property (@(posedge clk) disable iff (!rst_n)
    blk_full |=> (state_r == sha256_pkg::ST_ROUND) && (round_r == 6'd0))
    else $error("block fill did not start rounds");

  a_round_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha256_pkg::ST_ROUND) && (round_r != 6'd63)
      |=> (state_r == sha256_pkg::ST_ROUND) && (round_r == $past(round_r) + 6'd1))
    else $error("round counter skipped");

  // digest only comes out with the padded last block fully consumed
  a_out_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (byte_cnt_r == 6'd0) && pad_act_r && final_blk_r)
    else $error("digest output with a partial block");

  a_out_reset: assert property (@(posedge clk) disable iff (!rst_n)
    out_done |=> (state_r == sha256_pkg::ST_IDLE) && (msg_len_r == 61'd0)
      && (idx_r == 3'd0) && !pad_act_r)
    else $error("state not cleared after digest");
`endif

endmodule

[sim/sha256_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_tb_pkg
// Request codes and the digest word record shared by the testbench files.
// ----------------------------------------------------------------------------
package sha256_tb_pkg;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

endpackage

[sim/sha256_digest_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both channels of the digest engine, hashes every accepted byte in
// its own SHA-256 model and compares each digest word in order.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_msg_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int unsigned fail_count,
  output int unsigned words_due
);

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [31:0]                 hash_q [8];
  logic [31:0]                 block_words [16];
  logic [5:0]                  block_fill;
  logic [60:0]                 msg_len;
  sha256_tb_pkg::digest_word_t digest_q [$];

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic restart_message();
    for (int k = 0; k < 8; k++) hash_q[k] = START_HASH[k];
    for (int k = 0; k < 16; k++) block_words[k] = '0;
    block_fill = '0;
    msg_len = '0;
  endtask

  task automatic place_byte(input logic [5:0] pos, input logic [7:0] b);
    int sh;
    sh = 8 * (3 - int'(pos[1:0]));
    block_words[pos[5:2]][sh +: 8] = b;
  endtask

  // 64 rounds over the current block, then clear the block for the next one
  task automatic fold_block();
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] w, x15, x2, t1, t2;
    a = hash_q[0]; b = hash_q[1]; c = hash_q[2]; d = hash_q[3];
    e = hash_q[4]; f = hash_q[5]; g = hash_q[6]; h = hash_q[7];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        w = block_words[i];
      end else begin
        x15 = block_words[(i + 1) % 16];
        x2  = block_words[(i + 14) % 16];
        w = block_words[i % 16] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
          + block_words[(i + 9) % 16] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
        block_words[i % 16] = w;
      end
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_CONST[i] + w;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e;
      e = d + t1;
      d = c; c = b; b = a;
      a = t1 + t2;
    end
    hash_q[0] += a; hash_q[1] += b; hash_q[2] += c; hash_q[3] += d;
    hash_q[4] += e; hash_q[5] += f; hash_q[6] += g; hash_q[7] += h;
    for (int k = 0; k < 16; k++) block_words[k] = '0;
  endtask

  // padding, length block(s) and the eight digest words of the message
  task automatic finish_message();
    logic [63:0]                 bit_len;
    sha256_tb_pkg::digest_word_t dw;
    bit_len = {msg_len, 3'b000};
    place_byte(block_fill, 8'h80);
    if (block_fill >= 6'd56) fold_block();
    block_words[14] = bit_len[63:32];
    block_words[15] = bit_len[31:0];
    fold_block();
    for (int k = 0; k < 8; k++) begin
      dw.word  = hash_q[k];
      dw.index = 3'(k);
      dw.last  = (k == 7);
      digest_q.push_back(dw);
    end
    restart_message();
  endtask

  always @(posedge clk) begin
    sha256_tb_pkg::digest_word_t want;
    if (!rst_n) begin
      restart_message();
      digest_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest transaction, expected none, actual %h %0d %0b",
                   $time, out_digest_word, out_word_index, out_last_word);
          fail_count++;
        end else begin
          want = digest_q.pop_front();
          if (out_digest_word !== want.word) begin
            $display("%0t: digest_word mismatch, expected %h, actual %h",
                     $time, want.word, out_digest_word);
            fail_count++;
          end
          if (out_word_index !== want.index) begin
            $display("%0t: word_index mismatch, expected %0d, actual %0d",
                     $time, want.index, out_word_index);
            fail_count++;
          end
          if (out_last_word !== want.last) begin
            $display("%0t: last_word mismatch, expected %0b, actual %0b",
                     $time, want.last, out_last_word);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_req_type == sha256_tb_pkg::REQ_FINISH) begin
          finish_message();
        end else begin
          place_byte(block_fill, in_msg_byte);
          msg_len = msg_len + 61'd1;
          block_fill = block_fill + 6'd1;
          if (block_fill == 6'd0) fold_block();
        end
      end
    end
    words_due = digest_q.size();
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives byte messages and finish requests into the SHA-256 engine with random
// gaps and output back-pressure; the checker predicts and compares digests.
// ----------------------------------------------------------------------------
module tb_top;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic [7:0]  in_msg_byte;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;
  int unsigned fail_count;
  int unsigned words_due;
  bit          burst_mode;

  sha256_message_digest dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_msg_byte     (in_msg_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  sha256_digest_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_msg_byte     (in_msg_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word),
    .fail_count      (fail_count),
    .words_due       (words_due)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Called just after a falling edge; returns just after the falling edge
  // that follows acceptance. Valid stays high into the next call.
  task automatic send_item(input logic req, input logic [7:0] b);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_msg_byte <= 8'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_msg_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      send_item(sha256_tb_pkg::REQ_APPEND, 8'($urandom_range(0, 255)));
    end
    send_item(sha256_tb_pkg::REQ_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // result side: random stall per transaction, one long hold-off, one quiet stretch
  initial begin : receiver
    int unsigned hold;
    int unsigned taken;
    hold = 0;
    taken = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        taken++;
        if (taken == 36) hold = 400;
        else if (taken >= 48 && taken < 96) hold = 0;
        else hold = $urandom_range(0, 17);
      end
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned len;
    int unsigned edge_lens [10];
    edge_lens = '{55, 56, 64, 120, 57, 62, 63, 65, 119, 128};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = sha256_tb_pkg::REQ_APPEND;
    in_msg_byte = 8'h00;
    burst_mode = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty message, "abc", extreme byte values, back-to-back finishes
    send_item(sha256_tb_pkg::REQ_FINISH, 8'hff);
    send_item(sha256_tb_pkg::REQ_APPEND, 8'h61);
    send_item(sha256_tb_pkg::REQ_APPEND, 8'h62);
    send_item(sha256_tb_pkg::REQ_APPEND, 8'h63);
    send_item(sha256_tb_pkg::REQ_FINISH, 8'h00);
    burst_mode = 1'b1;
    send_item(sha256_tb_pkg::REQ_APPEND, 8'h00);
    send_item(sha256_tb_pkg::REQ_APPEND, 8'hff);
    send_item(sha256_tb_pkg::REQ_APPEND, 8'h55);
    send_item(sha256_tb_pkg::REQ_APPEND, 8'haa);
    send_item(sha256_tb_pkg::REQ_FINISH, 8'h00);
    burst_mode = 1'b0;
    send_item(sha256_tb_pkg::REQ_FINISH, 8'h5a);
    send_item(sha256_tb_pkg::REQ_FINISH, 8'ha5);

    // marker just fits, marker spills into a second block, exact full block,
    // one full block followed by a spilling marker
    sent = 0;
    foreach (edge_lens[k]) begin
      if (k > 3) break;
      burst_mode = ($urandom_range(0, 3) == 0);
      send_message(edge_lens[k]);
      sent += edge_lens[k] + 1;
    end

    while (sent < 310) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 2) len = edge_lens[$urandom_range(0, 9)];
      else len = $urandom_range(0, 30);
      send_message(len);
      sent += len + 1;
    end

    in_valid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
